// ===== src/gab_pkg.sv =====
// Shared types, constants and helpers for the GEMM alpha/beta core.
`timescale 1ns / 1ps

package gab_pkg;

    localparam int MAX_DIM_DEFAULT = 16;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int DIM_W   = 5;
    localparam int IDX_W   = 4;
    localparam int ACC_W   = 72;
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] BETA_RESET  = 32'h0000_0000;
    localparam logic [DIM_W-1:0]  DIM_RESET   = 5'd16;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] REG_ALPHA   = 3'd0;
    localparam logic [2:0] REG_BETA    = 3'd1;
    localparam logic [2:0] REG_ROWS_M  = 3'd2;
    localparam logic [2:0] REG_INNER_K = 3'd3;
    localparam logic [2:0] REG_COLS_N  = 3'd4;

    typedef enum logic [1:0] {
        KIND_LOAD_A  = 2'd0,
        KIND_LOAD_B  = 2'd1,
        KIND_LOAD_C  = 2'd2,
        KIND_COMPUTE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] element_value;
    } item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         result_row;
        logic [IDX_W-1:0]         result_col;
        logic signed [DATA_W-1:0] result_value;
        logic                     status;
    } result_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] alpha;
        logic signed [DATA_W-1:0] beta;
        logic [DIM_W-1:0]         rows_m;
        logic [DIM_W-1:0]         inner_k;
        logic [DIM_W-1:0]         cols_n;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MAC,
        ST_DRAIN,
        ST_SAT,
        ST_SCALE,
        ST_SUM,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic take_item;
        logic write_load;
        logic mac_start;
        logic mac_issue;
        logic sat;
        logic scale;
        logic sum;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic ok;
        logic compute;
        logic issue_done;
        logic pipe_busy;
        logic out_free;
    } stat_t;

    // floor to Q16.16 and saturate to 32 bits
    function automatic logic [DATA_W-1:0] floor_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-32:0]       top;
        sh  = v >>> FRAC_W;
        top = sh[ACC_W-1:DATA_W-1];
        if ((&top) || (~|top))
            floor_sat = sh[DATA_W-1:0];
        else if (sh[ACC_W-1])
            floor_sat = SAT_MIN;
        else
            floor_sat = SAT_MAX;
    endfunction

endpackage

// ===== src/gab_ctrl.sv =====
// Sequencing state machine for load, multiply-accumulate and result steps.
`timescale 1ns / 1ps

module gab_ctrl
    import gab_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                if (!stat.ok)
                    state_next = ST_EMIT;
                else if (!stat.compute)
                    state_next = ST_IDLE;
                else
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (stat.issue_done)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                    state_next = ST_SAT;
            end
            ST_SAT:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall    = 1'b0;
                cmd.take_item = item_valid;
            end
            ST_DECODE:
            begin
                cmd.write_load = stat.ok && !stat.compute;
                cmd.mac_start  = stat.ok && stat.compute;
            end
            ST_MAC:   cmd.mac_issue = !stat.issue_done;
            ST_DRAIN: cmd = '0;
            ST_SAT:   cmd.sat = 1'b1;
            ST_SCALE: cmd.scale = 1'b1;
            ST_SUM:   cmd.sum = 1'b1;
            ST_EMIT:  cmd.load_out = stat.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

// ===== src/gab_dp.sv =====
// Datapath: matrix stores, multiply-accumulate pipe, alpha/beta scaling, result register.
`timescale 1ns / 1ps

module gab_dp
    import gab_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  cmd_t    cmd,
    output stat_t   stat,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIMW   = $clog2(MAX_DIM + 1);
    localparam int CMP_W  = (DIMW > IDX_W) ? DIMW : IDX_W;

    logic [DATA_W-1:0] a_mem [DEPTH];
    logic [DATA_W-1:0] b_mem [DEPTH];
    logic [DATA_W-1:0] c_mem [DEPTH];

    kind_t                    kind_reg;
    logic [IDX_W-1:0]         row_reg;
    logic [IDX_W-1:0]         col_reg;
    logic [DATA_W-1:0]        val_reg;

    logic [DIMW-1:0]          l_reg;
    logic [DATA_W-1:0]        a_rd_reg;
    logic [DATA_W-1:0]        b_rd_reg;
    logic [DATA_W-1:0]        c_rd_reg;
    logic                     rd_v_reg;
    logic signed [63:0]       prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DATA_W-1:0]        s_reg;
    logic signed [63:0]       pa_reg;
    logic signed [63:0]       pb_reg;
    logic [DATA_W-1:0]        res_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic [DIMW-1:0]   m_eff;
    logic [DIMW-1:0]   k_eff;
    logic [DIMW-1:0]   n_eff;
    logic [CMP_W-1:0]  row_x;
    logic [CMP_W-1:0]  col_x;
    logic              ok;
    logic [ADDR_W-1:0] addr_rc;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic              a_we;
    logic              b_we;
    logic              c_we;
    logic [DATA_W-1:0] c_wdata;
    logic signed [64:0] fin_sum;
    logic [DATA_W-1:0] res_next;
    logic              out_free;

    // dimensions above the store size count as the store size
    assign m_eff = (cfg.rows_m  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(cfg.rows_m);
    assign k_eff = (cfg.inner_k > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(cfg.inner_k);
    assign n_eff = (cfg.cols_n  > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(cfg.cols_n);

    assign row_x = CMP_W'(row_reg);
    assign col_x = CMP_W'(col_reg);

    always_comb
    begin
        case (kind_reg)
            KIND_LOAD_A: ok = (row_x < CMP_W'(m_eff)) && (col_x < CMP_W'(k_eff));
            KIND_LOAD_B: ok = (row_x < CMP_W'(k_eff)) && (col_x < CMP_W'(n_eff));
            KIND_LOAD_C: ok = (row_x < CMP_W'(m_eff)) && (col_x < CMP_W'(n_eff));
            KIND_COMPUTE: ok = (row_x < CMP_W'(m_eff)) && (col_x < CMP_W'(n_eff));
            default:     ok = 1'b0;
        endcase
    end

    assign addr_rc = ADDR_W'(int'(row_reg) * MAX_DIM + int'(col_reg));
    assign a_addr  = cmd.write_load ? addr_rc
                                    : ADDR_W'(int'(row_reg) * MAX_DIM + int'(l_reg));
    assign b_addr  = cmd.write_load ? addr_rc
                                    : ADDR_W'(int'(l_reg) * MAX_DIM + int'(col_reg));

    assign a_we    = cmd.write_load && (kind_reg == KIND_LOAD_A);
    assign b_we    = cmd.write_load && (kind_reg == KIND_LOAD_B);
    assign c_we    = (cmd.write_load && (kind_reg == KIND_LOAD_C)) || cmd.sum;
    assign c_wdata = cmd.sum ? res_next : val_reg;

    assign fin_sum  = {pa_reg[63], pa_reg} + {pb_reg[63], pb_reg};
    assign res_next = floor_sat({{(ACC_W-65){fin_sum[64]}}, fin_sum});

    assign out_free = !out_valid_reg || !result_stall;

    assign stat.ok         = ok;
    assign stat.compute    = (kind_reg == KIND_COMPUTE);
    assign stat.issue_done = (l_reg == k_eff);
    assign stat.pipe_busy  = rd_v_reg || prod_v_reg;
    assign stat.out_free   = out_free;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // memories: one port each, registered read data
    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_addr] <= val_reg;
        if (cmd.mac_issue)
            a_rd_reg <= a_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            b_mem[b_addr] <= val_reg;
        if (cmd.mac_issue)
            b_rd_reg <= b_mem[b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            c_mem[addr_rc] <= c_wdata;
        if (cmd.mac_start)
            c_rd_reg <= c_mem[addr_rc];
    end

    // control state of the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            l_reg         <= '0;
        end
        else
        begin
            rd_v_reg   <= cmd.mac_issue;
            prod_v_reg <= rd_v_reg;
            if (cmd.mac_start)
                l_reg <= '0;
            else if (cmd.mac_issue)
                l_reg <= l_reg + 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            kind_reg <= item.kind;
            row_reg  <= item.row;
            col_reg  <= item.col;
            val_reg  <= item.element_value;
        end
        if (rd_v_reg)
            prod_reg <= $signed(a_rd_reg) * $signed(b_rd_reg);
        if (cmd.mac_start)
            acc_reg <= '0;
        else if (prod_v_reg)
            acc_reg <= acc_reg + {{(ACC_W-64){prod_reg[63]}}, prod_reg};
        if (cmd.sat)
            s_reg <= floor_sat(acc_reg);
        if (cmd.scale)
        begin
            pa_reg <= cfg.alpha * $signed(s_reg);
            pb_reg <= cfg.beta * $signed(c_rd_reg);
        end
        if (cmd.sum)
            res_reg <= res_next;
        if (cmd.load_out)
        begin
            out_reg.result_row   <= row_reg;
            out_reg.result_col   <= col_reg;
            out_reg.result_value <= ok ? res_reg : '0;
            out_reg.status       <= !ok;
        end
    end

endmodule

// ===== src/gemm_alpha_beta_core.sv =====
// Top level of the GEMM alpha/beta core: configuration registers and block wiring.
//
// Usage:
//   Item channel (item_valid/item_stall/item): load transactions write one
//   element of A, B or C; a compute transaction names C(row,col) and yields
//   alpha*sum(A(row,l)*B(l,col)) + beta*C(row,col) in Q16.16, saturated,
//   which is written back to C and sent out.
//   Result channel (result_valid/result_stall/result): one transaction per
//   compute and per out-of-range item (status 1, value 0); in-range loads
//   produce none.
//   Sequence: a load is taken, then written in the decode step. A compute runs
//   one multiply-accumulate per cycle through the single A and B read ports,
//   then drain, saturate, scale and sum steps. Items are taken one at a time.
//   The result sits in an output register, so the next item is accepted while
//   the receiver stalls; a second result then waits until the first is taken.
//   Reset clears control state and loads alpha=1.0, beta=0, all dims 16.
//   Store contents are undefined until written. Configure through APB only
//   while idle.
`timescale 1ns / 1ps

module gemm_alpha_beta_core
    import gab_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [DATA_W-1:0] alpha_reg;
    logic [DATA_W-1:0] beta_reg;
    logic [DIM_W-1:0]  rows_m_reg;
    logic [DIM_W-1:0]  inner_k_reg;
    logic [DIM_W-1:0]  cols_n_reg;

    logic       wr_en;
    logic [2:0] reg_idx;
    cfg_t       cfg;
    cmd_t       cmd;
    stat_t      stat;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg   <= ALPHA_RESET;
            beta_reg    <= BETA_RESET;
            rows_m_reg  <= DIM_RESET;
            inner_k_reg <= DIM_RESET;
            cols_n_reg  <= DIM_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ALPHA:   alpha_reg   <= pwdata;
                REG_BETA:    beta_reg    <= pwdata;
                REG_ROWS_M:  rows_m_reg  <= pwdata[DIM_W-1:0];
                REG_INNER_K: inner_k_reg <= pwdata[DIM_W-1:0];
                REG_COLS_N:  cols_n_reg  <= pwdata[DIM_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ALPHA:   prdata = alpha_reg;
            REG_BETA:    prdata = beta_reg;
            REG_ROWS_M:  prdata = PDATA_W'(rows_m_reg);
            REG_INNER_K: prdata = PDATA_W'(inner_k_reg);
            REG_COLS_N:  prdata = PDATA_W'(cols_n_reg);
            default:     prdata = '0;
        endcase
    end

    assign cfg.alpha   = alpha_reg;
    assign cfg.beta    = beta_reg;
    assign cfg.rows_m  = rows_m_reg;
    assign cfg.inner_k = inner_k_reg;
    assign cfg.cols_n  = cols_n_reg;

    gab_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    gab_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== src/gab_checker.sv =====
// Port-level assertions for the GEMM alpha/beta core, bound to the top level.
`timescale 1ns / 1ps

module gab_checker
    import gab_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result,
    input logic    pready
);

    // a result waiting on the receiver stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // and keeps its payload
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result payload changed while stalled");

    // an accepted item is decoded before the next is taken
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("item accepted back to back");

    // an error result carries a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status |-> result.result_value == '0)
        else $error("error result with nonzero value");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind gemm_alpha_beta_core gab_checker u_gab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .pready       (pready)
);
